>>> hw/rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Types and codes shared by the sorted cursor list controller and datapath.
// ----------------------------------------------------------------------------
package scl_pkg;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_FWD    = 2'd2,
		REQ_BACK   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	localparam int unsigned KEY_W   = 8;
	localparam int unsigned HP_W    = 16;
	localparam int unsigned AC_W    = 8;
	localparam int unsigned TAG_W   = 8;
	localparam int unsigned CNTO_W  = 5;
	localparam int unsigned ROUND_W = 16;
	localparam int unsigned IN_W    = 48;
	localparam int unsigned OUT_W   = 64;

	typedef struct packed {
		logic [TAG_W-1:0]        tag;
		logic [AC_W-1:0]         ac;
		logic signed [HP_W-1:0]  hp;
		logic signed [KEY_W-1:0] key;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // take an input item
		logic ins_empty;   // place new entry into an empty table
		logic ins_begin;   // start scan from the last entry
		logic ins_shift;   // compare one entry, shift or place
		logic ins_place0;  // place new entry at the head
		logic del_begin;   // start closing the gap at the cursor
		logic del_shift;   // move one entry down
		logic del_finish;  // drop count, fix cursor
		logic step;        // move cursor forward or back
		logic emit;        // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req;
		logic refused;
		logic cnt_zero;
		logic ins_stop;
		logic idx_zero;
		logic del_any;
		logic del_more;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/scl_ctrl.sv
// ----------------------------------------------------------------------------
// scl_ctrl
// Sequencer for the sorted cursor list: dispatches one request at a time and
// walks the datapath through scan, shift, fetch and result.
// ----------------------------------------------------------------------------
module scl_ctrl
	import scl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_DISPATCH  = 8'b0000_0010,
		S_INS_SHIFT = 8'b0000_0100,
		S_INS_LAST  = 8'b0000_1000,
		S_DEL_SHIFT = 8'b0001_0000,
		S_FETCH     = 8'b0010_0000,
		S_RESULT    = 8'b0100_0000,
		S_SPARE     = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FETCH;
				if (!sts.refused) begin
					unique case (sts.req)
						REQ_INSERT: begin
							if (sts.cnt_zero) begin
								cmd.ins_empty = 1'b1;
							end else begin
								cmd.ins_begin = 1'b1;
								state_d       = S_INS_SHIFT;
							end
						end
						REQ_DELETE: begin
							if (sts.del_any) begin
								cmd.del_begin = 1'b1;
								state_d       = S_DEL_SHIFT;
							end else begin
								cmd.del_finish = 1'b1;
							end
						end
						REQ_FWD, REQ_BACK: begin
							cmd.step = 1'b1;
						end
						default: begin
							state_d = S_FETCH;
						end
					endcase
				end
			end
			S_INS_SHIFT: begin
				cmd.ins_shift = 1'b1;
				if (sts.ins_stop) begin
					state_d = S_FETCH;
				end else if (sts.idx_zero) begin
					state_d = S_INS_LAST;
				end
			end
			S_INS_LAST: begin
				cmd.ins_place0 = 1'b1;
				state_d        = S_FETCH;
			end
			S_DEL_SHIFT: begin
				cmd.del_shift = 1'b1;
				if (!sts.del_more) begin
					cmd.del_finish = 1'b1;
					state_d        = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/scl_dp.sv
// ----------------------------------------------------------------------------
// scl_dp
// Datapath of the sorted cursor list: entry memory, count, cursor, round
// counter, scan index and the result register.
// ----------------------------------------------------------------------------
module scl_dp
	import scl_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [IN_W-1:0]  in_data,
	output logic [OUT_W-1:0] out_data,
	output logic             out_valid,
	input  logic             out_ready
);

	localparam int unsigned IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CXW = CW + 1;

	entry_t mem [MAX_ENTRIES];
	entry_t rd_q;
	entry_t fresh_q;
	req_t   req_q;
	status_t stat_q;

	logic [CW-1:0]      count_q;
	logic [IW-1:0]      cursor_q;
	logic [IW-1:0]      idx_q;
	logic [ROUND_W-1:0] round_q;
	logic               out_valid_q;

	status_t            o_stat_q;
	entry_t             o_entry_q;
	logic [CNTO_W-1:0]  o_count_q;
	logic [ROUND_W-1:0] o_round_q;
	logic               o_empty_q;

	logic [CXW-1:0] count_x;
	logic [CXW-1:0] cur_inc_x;
	logic [CXW-1:0] idx_x;
	logic           pos_le_cur;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic [IW-1:0] rd_addr;

	req_t   in_req;
	entry_t in_entry;
	status_t new_stat;

	assign in_req       = req_t'(in_data[1:0]);
	assign in_entry.key = in_data[9:2];
	assign in_entry.hp  = in_data[25:10];
	assign in_entry.ac  = in_data[33:26];
	assign in_entry.tag = in_data[41:34];

	assign count_x   = CXW'(count_q);
	assign cur_inc_x = CXW'(cursor_q) + CXW'(1);
	assign idx_x     = CXW'(idx_q);
	// new entry lands at idx+1; cursor moves when that is at or before it
	assign pos_le_cur = ((idx_x + CXW'(1)) <= CXW'(cursor_q));

	always_comb begin
		if (in_req == REQ_INSERT && count_q == CW'(MAX_ENTRIES)) begin
			new_stat = ST_FULL;
		end else if (in_req != REQ_INSERT && count_q == '0) begin
			new_stat = ST_EMPTY;
		end else begin
			new_stat = ST_DONE;
		end
	end

	assign sts.req      = req_q;
	assign sts.refused  = (stat_q != ST_DONE);
	assign sts.cnt_zero = (count_q == '0);
	assign sts.ins_stop = (rd_q.key >= fresh_q.key);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.del_any  = (cur_inc_x < count_x);
	assign sts.del_more = ((idx_x + CXW'(2)) < count_x);
	assign sts.out_free = !out_valid_q || out_ready;

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = fresh_q;
		rd_addr = cursor_q;
		if (cmd.ins_empty || cmd.ins_place0) begin
			wr_en   = 1'b1;
			wr_addr = '0;
		end
		if (cmd.ins_begin) begin
			rd_addr = IW'(count_q - CW'(1));
		end
		if (cmd.ins_shift) begin
			wr_en   = 1'b1;
			wr_addr = IW'(idx_x + CXW'(1));
			wr_data = sts.ins_stop ? fresh_q : rd_q;
			rd_addr = idx_q - IW'(1);
		end
		if (cmd.del_begin) begin
			rd_addr = IW'(cur_inc_x);
		end
		if (cmd.del_shift) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_data = rd_q;
			rd_addr = IW'(idx_x + CXW'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_empty) begin
				count_q  <= CW'(1);
				cursor_q <= '0;
			end
			if (cmd.ins_begin) begin
				idx_q <= IW'(count_q - CW'(1));
			end
			if (cmd.ins_shift) begin
				if (sts.ins_stop) begin
					count_q <= count_q + CW'(1);
					if (pos_le_cur) begin
						cursor_q <= cursor_q + IW'(1);
					end
				end else if (!sts.idx_zero) begin
					idx_q <= idx_q - IW'(1);
				end
			end
			if (cmd.ins_place0) begin
				count_q  <= count_q + CW'(1);
				cursor_q <= cursor_q + IW'(1);
			end
			if (cmd.del_begin) begin
				idx_q <= cursor_q;
			end
			if (cmd.del_shift && sts.del_more) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.del_finish) begin
				count_q <= count_q - CW'(1);
				// cursor was on the last entry: wrap to the head
				if (cur_inc_x >= count_x) begin
					cursor_q <= '0;
				end
			end
			if (cmd.step) begin
				if (req_q == REQ_FWD) begin
					if (cur_inc_x >= count_x) begin
						cursor_q <= '0;
						round_q  <= round_q + ROUND_W'(1);
					end else begin
						cursor_q <= cursor_q + IW'(1);
					end
				end else begin
					if (cursor_q == '0) begin
						cursor_q <= IW'(count_q - CW'(1));
						round_q  <= round_q - ROUND_W'(1);
					end else begin
						cursor_q <= cursor_q - IW'(1);
					end
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= in_req;
			fresh_q <= in_entry;
			stat_q  <= new_stat;
		end
		if (cmd.emit) begin
			o_stat_q  <= stat_q;
			o_entry_q <= (count_q == '0) ? '0 : rd_q;
			o_count_q <= CNTO_W'(count_q);
			o_round_q <= round_q;
			o_empty_q <= (count_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {o_empty_q, o_round_q, o_count_q, o_entry_q.tag, o_entry_q.ac,
		o_entry_q.hp, o_entry_q.key, o_stat_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_cursor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (cursor_q == '0))
		else $error("cursor off head while table empty");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (CXW'(cursor_q) < count_x))
		else $error("cursor beyond last entry");

	a_scan_down: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins_shift && !sts.ins_stop && !sts.idx_zero) |=>
		(idx_q == $past(idx_q) - IW'(1)))
		else $error("insert scan index did not step down");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result not presented after emit");
`endif

endmodule

>>> hw/rtl/sorted_cursor_list_core.sv
// ----------------------------------------------------------------------------
// sorted_cursor_list_core
// Sorted table with a round-robin cursor, stream in, stream out.
// ----------------------------------------------------------------------------
// Holds up to MAX_ENTRIES entries in descending key order (equal keys keep
// arrival order) with a cursor and a signed 16-bit round counter. Each input
// item carries one request (insert, delete current, step forward, step back)
// and yields exactly one result item describing the state afterward. Items
// are handled one at a time through an entry memory with one read and one
// write port. After an item is accepted the sequencer dispatches it; an insert
// into a non-empty table then scans from the last entry, moving each entry
// that falls behind the new one and placing the new one, and a delete moves
// each entry after the cursor down; then the current entry is fetched and the
// result is presented in the same cycle in which the next item can be
// accepted. Insert and delete shift one entry per cycle through the memory.
// A new item may be accepted while the previous result still waits on the
// output. No clearing pass after reset: unwritten slots are never used.
module sorted_cursor_list_core
	import scl_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// req_type[1:0], sort_key[9:2], hit_points[25:10], armor_class[33:26],
	// entry_tag[41:34], zero fill [47:42]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status[1:0], cur_key[9:2], cur_hp[25:10], cur_ac[33:26], cur_tag[41:34],
	// count_out[46:42], round_out[62:47], is_empty[63]
	output logic [OUT_W-1:0] m_tdata
);

	cmd_t cmd;
	sts_t sts;

	scl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scl_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.out_data  (m_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

endmodule

>>> sim/tb_sorted_cursor_list_core.sv
// ----------------------------------------------------------------------------
// tb_sorted_cursor_list_core
// Self-checking bench for the sorted cursor list core.
// ----------------------------------------------------------------------------
// A directed table covers the empty and full tables, wraps in both directions,
// equal keys, and deletes at the head and the tail. Random request mixes then
// fill and drain the table in turn. Result items are checked field by field
// against a behavioral table, or for fixed rows fixed values. Both stream
// sides stall at random, and the output is held off once for a long stretch.
module tb_sorted_cursor_list_core;
	import scl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH        = 16;
	localparam int          RANDOM_ITEMS = 1900;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          TAIL_CYCLES  = 40;
	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          PLAN_ROWS    = 24;

	typedef struct packed {
		logic [5:0]              pad;
		logic [TAG_W-1:0]        tag;
		logic [AC_W-1:0]         ac;
		logic signed [HP_W-1:0]  hp;
		logic signed [KEY_W-1:0] key;
		req_t                    req;
	} request_t;

	typedef struct packed {
		logic                      is_empty;
		logic signed [ROUND_W-1:0] round;
		logic [CNTO_W-1:0]         count;
		logic [TAG_W-1:0]          tag;
		logic [AC_W-1:0]           ac;
		logic signed [HP_W-1:0]    hp;
		logic signed [KEY_W-1:0]   key;
		logic [1:0]                status;
	} result_t;

	typedef struct {
		req_t req;
		int   key;
		int   hp;
		int   ac;
		int   tag;
		int   reps;
		bit   fixed;
		int   w_status;
		int   w_key;
		int   w_hp;
		int   w_ac;
		int   w_tag;
		int   w_count;
		int   w_round;
		int   w_empty;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	result_t           pending_results[$];
	int unsigned       mismatches = 0;
	int                cycle_count = 0;
	bit                steady = 1'b0;
	bit                hold_req = 1'b0;

	// behavioral copy of the table
	entry_t            roster[DEPTH];
	int                roster_len = 0;
	int                cursor = 0;
	logic [ROUND_W-1:0] round_ctr = '0;

	// request, key, hp, ac, tag, repeat, fixed expectation:
	// status, key, hp, ac, tag, count, round, empty
	plan_row_t plan [PLAN_ROWS] = '{
		'{REQ_DELETE, 0, 0, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0, 0, 0, 0, 1},
		'{REQ_FWD, 127, -1, 255, 255, 1, 1, ST_EMPTY, 0, 0, 0, 0, 0, 0, 1},
		'{REQ_BACK, -128, 32767, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0, 0, 0, 0, 1},
		'{REQ_INSERT, 0, -32768, 0, 1, 1, 1, ST_DONE, 0, -32768, 0, 1, 1, 0, 0},
		'{REQ_FWD, 0, 0, 0, 0, 1, 1, ST_DONE, 0, -32768, 0, 1, 1, 1, 0},
		'{REQ_BACK, 0, 0, 0, 0, 1, 1, ST_DONE, 0, -32768, 0, 1, 1, 0, 0},
		'{REQ_BACK, 0, 0, 0, 0, 1, 1, ST_DONE, 0, -32768, 0, 1, 1, -1, 0},
		'{REQ_INSERT, 127, 32767, 255, 255, 1, 1, ST_DONE, 0, -32768, 0, 1, 2, -1, 0},
		'{REQ_INSERT, -128, -1, 85, 170, 1, 1, ST_DONE, 0, -32768, 0, 1, 3, -1, 0},
		'{REQ_INSERT, 0, 100, 1, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_FWD, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_DELETE, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_DELETE, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_DELETE, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_INSERT, 64, 1234, 17, 33, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_INSERT, -5, 7, 7, 7, 1, 1, ST_FULL, 0, -32768, 0, 1, 16, -1, 0},
		'{REQ_FWD, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_BACK, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_DELETE, 0, 0, 0, 0, 16, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_BACK, 0, 0, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0, 0, 0, -1, 1},
		'{REQ_INSERT, -128, 0, 0, 0, 1, 1, ST_DONE, -128, 0, 0, 0, 1, -1, 0},
		'{REQ_INSERT, 127, -1, 255, 255, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_BACK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{REQ_DELETE, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	sorted_cursor_list_core #(
		.MAX_ENTRIES(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the table and return the state it leaves.
	function automatic result_t apply_request(request_t r);
		result_t res;
		entry_t  fresh;
		int      pos;
		int      i;
		res = '0;
		res.status = ST_DONE;
		if (r.req == REQ_INSERT) begin
			if (roster_len >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				fresh.key = r.key;
				fresh.hp  = r.hp;
				fresh.ac  = r.ac;
				fresh.tag = r.tag;
				// equal keys keep arrival order
				pos = 0;
				while (pos < roster_len && roster[pos].key >= r.key)
					pos++;
				for (i = roster_len; i > pos; i--)
					roster[i] = roster[i-1];
				roster[pos] = fresh;
				if (roster_len == 0)
					cursor = 0;
				else if (pos <= cursor)
					cursor++;
				roster_len++;
			end
		end else if (roster_len == 0) begin
			res.status = ST_EMPTY;
		end else if (r.req == REQ_DELETE) begin
			for (i = cursor; i + 1 < roster_len; i++)
				roster[i] = roster[i+1];
			roster_len--;
			if (cursor >= roster_len)
				cursor = 0;
		end else if (r.req == REQ_FWD) begin
			if (cursor + 1 >= roster_len) begin
				cursor = 0;
				round_ctr++;
			end else begin
				cursor++;
			end
		end else begin
			if (cursor == 0) begin
				cursor = roster_len - 1;
				round_ctr--;
			end else begin
				cursor--;
			end
		end
		if (roster_len > 0) begin
			res.key = roster[cursor].key;
			res.hp  = roster[cursor].hp;
			res.ac  = roster[cursor].ac;
			res.tag = roster[cursor].tag;
		end
		res.count    = CNTO_W'(roster_len);
		res.round    = round_ctr;
		res.is_empty = (roster_len == 0);
		return res;
	endfunction

	// Fill mode favors inserts, drain mode favors deletes.
	function automatic request_t random_request(bit filling);
		request_t r;
		int       pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < (filling ? 55 : 20))
			r.req = REQ_INSERT;
		else if (pick < (filling ? 70 : 60))
			r.req = REQ_DELETE;
		else if (pick < (filling ? 85 : 80))
			r.req = REQ_FWD;
		else
			r.req = REQ_BACK;
		case ($urandom_range(0, 3))
			0: r.key = $urandom_range(0, 1) ? 8'h7F : 8'h80;
			// crowd keys near zero so ties are common
			1: r.key = 8'($urandom_range(0, 4)) - 8'd2;
			default: r.key = 8'($urandom);
		endcase
		r.hp  = 16'($urandom);
		r.ac  = 8'($urandom);
		r.tag = 8'($urandom);
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_item(request_t r, result_t want);
		if (!steady) begin
			while ($urandom_range(0, 99) < 34) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(want);
	endtask

	task automatic await_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin
		request_t r;
		result_t  want;
		bit       filling;
		int       k;
		int       n;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[p]) begin
			for (k = 0; k < plan[p].reps; k++) begin
				r = '0;
				r.req = plan[p].req;
				r.key = 8'(plan[p].key);
				r.hp  = 16'(plan[p].hp);
				r.ac  = 8'(plan[p].ac);
				r.tag = 8'(plan[p].tag);
				want = apply_request(r);
				if (plan[p].fixed) begin
					want.status   = 2'(plan[p].w_status);
					want.key      = 8'(plan[p].w_key);
					want.hp       = 16'(plan[p].w_hp);
					want.ac       = 8'(plan[p].w_ac);
					want.tag      = 8'(plan[p].w_tag);
					want.count    = 5'(plan[p].w_count);
					want.round    = 16'(plan[p].w_round);
					want.is_empty = plan[p].w_empty[0];
				end
				send_item(r, want);
			end
		end
		await_results();

		filling = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				filling = !filling;
			// stall the output while items keep coming
			if (n == 300)
				hold_req = 1'b1;
			if (n == 1000)
				await_results();
			steady = (n >= 1200 && n < 1500);
			r = random_request(filling);
			want = apply_request(r);
			send_item(r, want);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 34);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("cur_key", want.key, got.key);
				check_field("cur_hp", want.hp, got.hp);
				check_field("cur_ac", want.ac, got.ac);
				check_field("cur_tag", want.tag, got.tag);
				check_field("count_out", want.count, got.count);
				check_field("round_out", want.round, got.round);
				check_field("is_empty", want.is_empty, got.is_empty);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
